/* design/clipped_palette_blit_core_macros.svh */
// Assertion macros shared by the blitter modules.
`ifndef CLIPPED_PALETTE_BLIT_CORE_MACROS_SVH
`define CLIPPED_PALETTE_BLIT_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CPB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define CPB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* design/cpb_pkg.sv */
// Shared constants, types and helper functions of the palette blitter.
package cpb_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int MAX_DIMENSION   = 4096;

   localparam int PAL_AW     = $clog2(PALETTE_ENTRIES);
   localparam int INDEX_W    = 8;
   localparam int RGB_W      = 24;
   localparam int DIM_W      = 13;
   localparam int CNT_W      = $clog2(MAX_DIMENSION);
   localparam int POS_W      = CNT_W + 1;
   localparam int ADDR_W     = 24;
   localparam int PROD_W     = POS_W + DIM_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEST_X        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEST_Y        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PIC_WIDTH     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PIC_HEIGHT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COLOUR_MODE   = 3'd6;

   // Input item kinds.
   localparam logic CMD_PALETTE = 1'b0;
   localparam logic CMD_PIXEL   = 1'b1;

   // Configuration as the datapath sees it: sizes saturated, origin clamped.
   typedef struct packed {
      logic [DIM_W-1:0] buf_w;
      logic [DIM_W-1:0] buf_h;
      logic [DIM_W-1:0] pic_w;
      logic [DIM_W-1:0] pic_h;
      logic [CNT_W-1:0] org_x;
      logic [CNT_W-1:0] org_y;
      logic             true_colour;
   } cfg_type;

   // Destination of the current source pixel.
   typedef struct packed {
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic             last;
   } pos_type;

   // Saturate a dimension to MAX_DIMENSION, and lift zero to one if asked.
   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                                input logic min_one);
      logic [DIM_W-1:0] r;
      r = v;
      if (min_one && (v == '0)) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIMENSION)) begin
         r = DIM_W'(MAX_DIMENSION);
      end
      return r;
   endfunction

   // Clamp a signed position to zero and keep the counter-wide part.
   function automatic logic [CNT_W-1:0] clamp_pos(input logic [DIM_W-1:0] v);
      return v[DIM_W-1] ? '0 : v[CNT_W-1:0];
   endfunction

   // True when an index names a palette entry that exists.
   function automatic logic pal_hit(input logic [INDEX_W-1:0] idx);
      return {1'b0, idx} < (INDEX_W + 1)'(PALETTE_ENTRIES);
   endfunction

endpackage

/* design/cpb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module cpb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/cpb_csr.sv */
// Configuration registers of the blitter, stored in datapath form.
module cpb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cpb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cpb_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output cpb_pkg::cfg_type                 cfg
);

   cpb_pkg::cfg_type cfg_ff;
   cpb_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;

   // Saturate and clamp on the way in, so the datapath sees ready values.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            cpb_pkg::REG_BUFFER_WIDTH:  cfg_in.buf_w = cpb_pkg::sat_dim(csr_wdata, 1'b0);
            cpb_pkg::REG_BUFFER_HEIGHT: cfg_in.buf_h = cpb_pkg::sat_dim(csr_wdata, 1'b0);
            cpb_pkg::REG_DEST_X:        cfg_in.org_x = cpb_pkg::clamp_pos(csr_wdata);
            cpb_pkg::REG_DEST_Y:        cfg_in.org_y = cpb_pkg::clamp_pos(csr_wdata);
            cpb_pkg::REG_PIC_WIDTH:     cfg_in.pic_w = cpb_pkg::sat_dim(csr_wdata, 1'b1);
            cpb_pkg::REG_PIC_HEIGHT:    cfg_in.pic_h = cpb_pkg::sat_dim(csr_wdata, 1'b1);
            cpb_pkg::REG_COLOUR_MODE:   cfg_in.true_colour = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buf_w       <= cpb_pkg::DIM_W'(640);
         cfg_ff.buf_h       <= cpb_pkg::DIM_W'(480);
         cfg_ff.pic_w       <= cpb_pkg::DIM_W'(1);
         cfg_ff.pic_h       <= cpb_pkg::DIM_W'(1);
         cfg_ff.org_x       <= '0;
         cfg_ff.org_y       <= '0;
         cfg_ff.true_colour <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/cpb_cursor.sv */
// Source column and row counters and the destination of the current pixel.
`include "clipped_palette_blit_core_macros.svh"

module cpb_cursor (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  cpb_pkg::cfg_type cfg,
   output cpb_pkg::pos_type pos
);

   logic [cpb_pkg::CNT_W-1:0] column_ff, column_in;
   logic [cpb_pkg::CNT_W-1:0] row_ff, row_in;
   logic [cpb_pkg::DIM_W-1:0] column_next;
   logic [cpb_pkg::DIM_W-1:0] row_next;
   logic                      last_col;
   logic                      last_row;

   assign column_next = cpb_pkg::DIM_W'(column_ff) + cpb_pkg::DIM_W'(1);
   assign row_next    = cpb_pkg::DIM_W'(row_ff) + cpb_pkg::DIM_W'(1);
   assign last_col    = column_next >= cfg.pic_w;
   assign last_row    = row_next >= cfg.pic_h;

   assign pos.col  = cpb_pkg::POS_W'(cfg.org_x) + cpb_pkg::POS_W'(column_ff);
   assign pos.row  = cpb_pkg::POS_W'(cfg.org_y) + cpb_pkg::POS_W'(row_ff);
   assign pos.last = last_col && last_row;

   // Wrap to the next row at the last column; restart after the last row.
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (advance) begin
         if (last_col) begin
            column_in = '0;
            row_in    = last_row ? '0 : row_next[cpb_pkg::CNT_W-1:0];
         end else begin
            column_in = column_next[cpb_pkg::CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   `CPB_ASSERT(a_reset_home, $past(reset) |-> (column_ff == '0 && row_ff == '0), "cursor not home after reset")
   `CPB_ASSERT(a_end_wraps, (advance && pos.last) |=> (column_ff == '0 && row_ff == '0), "cursor did not restart after picture end")

endmodule

/* design/clipped_palette_blit_core.sv */
// Top level of the clipped palette blitter: handshakes, palette RAM and output pipeline.
//
// Usage:
//   req channel carries one item per handshake: tuser = cmd (0 palette write,
//   1 source pixel); tdata = color_index then palette_rgb. Source pixels come
//   in row-major order over the full picture width.
//   rsp channel returns one item per source pixel and none for a palette
//   write: tuser = write_enable, tdata = pixel_address then pixel_data,
//   tlast = picture_end. A clipped pixel comes out with write_enable low and
//   zero address and data.
//   csr channel writes one register per handshake; it is always ready.
//   Write it only while no pixel is in flight.
// Timing:
//   An accepted pixel passes stage 1 and the output register on its way to rsp.
//   One item per cycle while rsp_tready is high: the palette is read once per
//   pixel at accept, and clipping and the address multiply run in the stage that receives the read data.
// Reset: counters restart at the picture origin and registers take their
//   defaults. The palette is not cleared and must be written before use.
// Stall: while rsp_tready is low a full output register holds; the stage behind
//   it holds its item and RAM read data, and req_tready drops once both are full.
`include "clipped_palette_blit_core_macros.svh"

module clipped_palette_blit_core (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: color_index [7:0], palette_rgb [31:8]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,
   // req_tuser: cmd [0]
   input  logic                              req_tuser,
   // rsp_tdata: pixel_address [23:0], pixel_data [47:24]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [47:0]                       rsp_tdata,
   // rsp_tuser: write_enable [0]
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cpb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cpb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   cpb_pkg::cfg_type cfg;
   cpb_pkg::pos_type pos;

   logic [cpb_pkg::INDEX_W-1:0] req_index;
   logic [cpb_pkg::RGB_W-1:0]   req_rgb;
   logic                        req_fire;
   logic                        pixel_fire;
   logic                        pal_write;
   logic [cpb_pkg::RGB_W-1:0]   pal_rd_data;

   // Stage 1: destination and index, palette read data arrives here.
   logic                        s1_valid_ff, s1_valid_in;
   cpb_pkg::pos_type            s1_pos_ff;
   logic [cpb_pkg::INDEX_W-1:0] s1_index_ff;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_we_ff;
   logic [cpb_pkg::ADDR_W-1:0]  rsp_addr_ff;
   logic [cpb_pkg::RGB_W-1:0]   rsp_data_ff;
   logic                        rsp_last_ff;

   logic                        out_free;
   logic                        s1_adv;
   logic                        in_frame;
   logic [cpb_pkg::PROD_W-1:0]  prod;
   logic [cpb_pkg::PROD_W-1:0]  lin_addr;
   logic [cpb_pkg::ADDR_W-1:0]  addr_in;
   logic [cpb_pkg::RGB_W-1:0]   data_in;

   assign req_index = req_tdata[cpb_pkg::INDEX_W-1:0];
   assign req_rgb   = req_tdata[cpb_pkg::INDEX_W +: cpb_pkg::RGB_W];

   // Advance stage 1 whenever the output register is empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign pixel_fire = req_fire && (req_tuser == cpb_pkg::CMD_PIXEL);
   assign pal_write  = req_fire && (req_tuser == cpb_pkg::CMD_PALETTE) &&
                       cpb_pkg::pal_hit(req_index);

   cpb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cpb_cursor u_cursor (
      .clock   (clock),
      .reset   (reset),
      .advance (pixel_fire),
      .cfg     (cfg),
      .pos     (pos)
   );

   // Read the palette at pixel accept; the read data holds until the next
   // pixel, so a stalled stage 1 keeps its colour.
   cpb_ram #(
      .WIDTH (cpb_pkg::RGB_W),
      .DEPTH (cpb_pkg::PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_write),
      .wr_addr (req_index[cpb_pkg::PAL_AW-1:0]),
      .wr_data (req_rgb),
      .rd_en   (pixel_fire),
      .rd_addr (req_index[cpb_pkg::PAL_AW-1:0]),
      .rd_data (pal_rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pixel_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_fire) begin
         s1_pos_ff   <= pos;
         s1_index_ff <= req_index;
      end
   end

   // Clip, then form row * buffer_width + column and pick the pixel data.
   assign in_frame = (s1_pos_ff.col < cpb_pkg::POS_W'(cfg.buf_w)) &&
                     (s1_pos_ff.row < cpb_pkg::POS_W'(cfg.buf_h));
   assign prod     = cpb_pkg::PROD_W'(s1_pos_ff.row) * cpb_pkg::PROD_W'(cfg.buf_w);
   assign lin_addr = prod + cpb_pkg::PROD_W'(s1_pos_ff.col);

   always_comb begin
      addr_in = '0;
      data_in = '0;
      if (in_frame) begin
         addr_in = lin_addr[cpb_pkg::ADDR_W-1:0];
         if (cfg.true_colour) begin
            data_in = cpb_pkg::pal_hit(s1_index_ff) ? pal_rd_data : '0;
         end else begin
            data_in = cpb_pkg::RGB_W'(s1_index_ff);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_we_ff   <= in_frame;
         rsp_addr_ff <= addr_in;
         rsp_data_ff <= data_in;
         rsp_last_ff <= s1_pos_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_we_ff;
   assign rsp_tdata  = {rsp_data_ff, rsp_addr_ff};
   assign rsp_tlast  = rsp_last_ff;

   `CPB_ASSERT(a_clip_zero, (rsp_valid_ff && !rsp_we_ff) |-> (rsp_addr_ff == '0 && rsp_data_ff == '0), "clipped pixel carries address or data")
   `CPB_ASSERT(a_pixel_lands, pixel_fire |=> s1_valid_ff, "accepted pixel did not reach stage 1")
   `CPB_ASSERT(a_stage_hold, (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_pos_ff) && $stable(pal_rd_data)), "stalled stage 1 lost its item")

endmodule
